>>> sv/fpa_pkg.sv
package fpa_pkg;

   localparam int INPUT_WIDTH_DEFAULT = 16;
   localparam int RATIO_SHIFT = 15;          // quotient bits of t
   localparam int OCTANT_SHIFT = 12;         // 4096 units per octant
   localparam int T2_WIDTH = 17;             // -(t*t) >> 15, signed
   localparam int POLY_WIDTH = 18;           // Horner accumulator, signed
   localparam int HORNER_STEPS = 4;
   localparam int ANGLE_WIDTH = 16;

   localparam logic signed [POLY_WIDTH-1:0] COEF_A = 18'sh00470;
   localparam logic signed [POLY_WIDTH-1:0] COEF_HORNER [HORNER_STEPS] =
      '{18'sh01029, 18'sh01F0B, 18'sh0364C, 18'sh0A2FC};

   // fold stage, divider steps, square, Horner steps, final multiply, output
   localparam int NUM_STAGES = 1 + RATIO_SHIFT + 1 + HORNER_STEPS + 1 + 1;

   typedef struct packed {
      logic [2:0] octant;
      logic       yzero;
   } fpa_meta_type;

endpackage

>>> sv/fpa_div_stage.sv
module fpa_div_stage import fpa_pkg::*; #(
   parameter int DEN_WIDTH = INPUT_WIDTH_DEFAULT + 1
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [DEN_WIDTH-1:0]   den_i,
   input  logic [DEN_WIDTH-1:0]   rem_i,
   input  logic [RATIO_SHIFT-1:0] quo_i,
   input  fpa_meta_type           meta_i,
   output logic [DEN_WIDTH-1:0]   den_o,
   output logic [DEN_WIDTH-1:0]   rem_o,
   output logic [RATIO_SHIFT-1:0] quo_o,
   output fpa_meta_type           meta_o
);

   logic [DEN_WIDTH:0]     shifted;
   logic [DEN_WIDTH:0]     diff;
   logic                   qbit;
   logic [DEN_WIDTH-1:0]   rem_in;

   // one restoring step: remainder stays below the divisor
   always_comb begin
      shifted = {rem_i, 1'b0};
      diff    = shifted - {1'b0, den_i};
      qbit    = (shifted >= {1'b0, den_i});
      rem_in  = qbit ? diff[DEN_WIDTH-1:0] : shifted[DEN_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_o  <= den_i;
         rem_o  <= rem_in;
         quo_o  <= {quo_i[RATIO_SHIFT-2:0], qbit};
         meta_o <= meta_i;
      end
   end

endmodule

>>> sv/fpa_horner_stage.sv
module fpa_horner_stage import fpa_pkg::*; (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [POLY_WIDTH-1:0] coef,
   input  logic signed [T2_WIDTH-1:0]   t2_i,
   input  logic [RATIO_SHIFT-1:0]       t_i,
   input  logic signed [POLY_WIDTH-1:0] p_i,
   input  fpa_meta_type                 meta_i,
   output logic signed [T2_WIDTH-1:0]   t2_o,
   output logic [RATIO_SHIFT-1:0]       t_o,
   output logic signed [POLY_WIDTH-1:0] p_o,
   output fpa_meta_type                 meta_o
);

   localparam int PROD_WIDTH = T2_WIDTH + POLY_WIDTH;

   logic signed [PROD_WIDTH-1:0] prod;
   logic signed [PROD_WIDTH-1:0] sum;

   always_comb begin
      prod = PROD_WIDTH'(t2_i) * PROD_WIDTH'(p_i);
      sum  = (prod >>> RATIO_SHIFT) + PROD_WIDTH'(coef);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t2_o   <= t2_i;
         t_o    <= t_i;
         p_o    <= sum[POLY_WIDTH-1:0];
         meta_o <= meta_i;
      end
   end

endmodule

>>> sv/fixed_point_atan2.sv
// Fixed-point atan2 of a signed vector, 32768 units per full turn.
//
// Input channel req_: req_x_value / req_y_value, taken at a clock edge with
// req_valid high and req_stall low. Result channel rsp_: rsp_angle, handed
// over at an edge with rsp_valid high and rsp_stall low.
//
// Stages: an accepted item passes one fold stage, fifteen restoring divider
// steps (one quotient bit each), a squaring stage, four Horner multiply
// stages, the final multiply and the output add on the way to rsp_valid.
// Throughput: one item per cycle unless stalled. Each stage holds only while
// it is full and the stage after it cannot move, so bubbles are squeezed
// out and new items are taken while a finished result waits on rsp_stall.
//
// Reset clears all stage valid bits; the pipeline is empty and ready in
// the cycle after reset drops. An item is never dropped or repeated under
// stall: a held stage keeps its contents until its successor frees up.
module fixed_point_atan2 import fpa_pkg::*; #(
   parameter int INPUT_WIDTH = INPUT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [INPUT_WIDTH-1:0] req_x_value,
   input  logic signed [INPUT_WIDTH-1:0] req_y_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ANGLE_WIDTH-1:0]        rsp_angle
);

   localparam int XW = INPUT_WIDTH + 2;     // signed fold domain
   localparam int DW = INPUT_WIDTH + 1;     // folded x reaches 2^INPUT_WIDTH
   localparam int SQ_STAGE = 1 + RATIO_SHIFT;
   localparam int HN_STAGE = SQ_STAGE + 1;
   localparam int MUL_STAGE = HN_STAGE + HORNER_STEPS;
   localparam int OUT_STAGE = MUL_STAGE + 1;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES:0]   ready;

   // a stage may load when it is empty or its contents move on
   always_comb begin
      ready[NUM_STAGES] = !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= (k == 0) ? req_valid : valid_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // fold into the first octant
   logic signed [XW-1:0] xa, ya, xb, yb, xt;
   logic [2:0]           oct;
   fpa_meta_type         meta_in;
   logic [DW-1:0]        den_in, rem_in;

   always_comb begin
      xa  = XW'(req_x_value);
      ya  = XW'(req_y_value);
      xb  = xa;
      yb  = ya;
      oct = 3'd0;
      if (yb < 0) begin
         xb  = -xb;
         yb  = -yb;
         oct = oct + 3'd4;
      end
      if (xb <= 0) begin
         xt  = xb;
         xb  = yb;
         yb  = -xt;
         oct = oct + 3'd2;
      end else begin
         xt = xb;
      end
      if (xb <= yb) begin
         xt  = yb - xb;
         xb  = xb + yb;
         yb  = xt;
         oct = oct + 3'd1;
      end
      meta_in.yzero = (ya == 0);
      if (ya == 0) begin
         meta_in.octant = (xa < 0) ? 3'd4 : 3'd0;
         den_in = DW'(1);
         rem_in = '0;
      end else begin
         meta_in.octant = oct;
         den_in = xb[DW-1:0];
         rem_in = yb[DW-1:0];
      end
   end

   logic [DW-1:0]          den_a  [RATIO_SHIFT+1];
   logic [DW-1:0]          rem_a  [RATIO_SHIFT+1];
   logic [RATIO_SHIFT-1:0] quo_a  [RATIO_SHIFT+1];
   fpa_meta_type           meta_a [RATIO_SHIFT+1];
   logic [DW-1:0]          den_ff;
   logic [DW-1:0]          rem_ff;
   fpa_meta_type           meta_ff;

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         den_ff  <= den_in;
         rem_ff  <= rem_in;
         meta_ff <= meta_in;
      end
   end

   assign den_a[0]  = den_ff;
   assign rem_a[0]  = rem_ff;
   assign quo_a[0]  = '0;
   assign meta_a[0] = meta_ff;

   for (genvar i = 0; i < RATIO_SHIFT; i++) begin : g_div
      fpa_div_stage #(.DEN_WIDTH(DW)) u_div (
         .clock  (clock),
         .en     (ready[i+1]),
         .den_i  (den_a[i]),
         .rem_i  (rem_a[i]),
         .quo_i  (quo_a[i]),
         .meta_i (meta_a[i]),
         .den_o  (den_a[i+1]),
         .rem_o  (rem_a[i+1]),
         .quo_o  (quo_a[i+1]),
         .meta_o (meta_a[i+1])
      );
   end

   // square stage: t2 = floor(-(t*t) / 2^15)
   logic [2*RATIO_SHIFT-1:0]   sq;
   logic signed [31:0]         nsq;
   logic signed [T2_WIDTH-1:0] t2_a   [HORNER_STEPS+1];
   logic [RATIO_SHIFT-1:0]     t_a    [HORNER_STEPS+1];
   logic signed [POLY_WIDTH-1:0] p_a  [HORNER_STEPS+1];
   fpa_meta_type               hm_a   [HORNER_STEPS+1];
   logic signed [T2_WIDTH-1:0] t2_ff;
   logic [RATIO_SHIFT-1:0]     t_ff;
   fpa_meta_type               hm_ff;

   always_comb begin
      sq  = quo_a[RATIO_SHIFT] * quo_a[RATIO_SHIFT];
      nsq = -$signed({2'b00, sq});
   end

   always_ff @(posedge clock) begin
      if (ready[SQ_STAGE]) begin
         t2_ff <= T2_WIDTH'(nsq >>> RATIO_SHIFT);
         t_ff  <= quo_a[RATIO_SHIFT];
         hm_ff <= meta_a[RATIO_SHIFT];
      end
   end

   assign t2_a[0] = t2_ff;
   assign t_a[0]  = t_ff;
   assign hm_a[0] = hm_ff;
   assign p_a[0]  = COEF_A;

   for (genvar h = 0; h < HORNER_STEPS; h++) begin : g_horner
      fpa_horner_stage u_horner (
         .clock  (clock),
         .en     (ready[HN_STAGE+h]),
         .coef   (COEF_HORNER[h]),
         .t2_i   (t2_a[h]),
         .t_i    (t_a[h]),
         .p_i    (p_a[h]),
         .meta_i (hm_a[h]),
         .t2_o   (t2_a[h+1]),
         .t_o    (t_a[h+1]),
         .p_o    (p_a[h+1]),
         .meta_o (hm_a[h+1])
      );
   end

   // final multiply by t
   localparam int PT_WIDTH = POLY_WIDTH + RATIO_SHIFT + 1;
   logic signed [PT_WIDTH-1:0]   pt;
   logic signed [POLY_WIDTH-1:0] pf_ff;
   fpa_meta_type                 fm_ff;

   always_comb begin
      pt = PT_WIDTH'(p_a[HORNER_STEPS]) *
           $signed({{(PT_WIDTH-RATIO_SHIFT){1'b0}}, t_a[HORNER_STEPS]});
   end

   always_ff @(posedge clock) begin
      if (ready[MUL_STAGE]) begin
         pf_ff <= POLY_WIDTH'(pt >>> RATIO_SHIFT);
         fm_ff <= hm_a[HORNER_STEPS];
      end
   end

   // round and add octant base
   logic signed [POLY_WIDTH-1:0] rnd;
   logic [ANGLE_WIDTH-1:0]       angle_in;
   logic [ANGLE_WIDTH-1:0]       angle_ff;

   always_comb begin
      rnd = (pf_ff + POLY_WIDTH'(4)) >>> 3;
      angle_in = ANGLE_WIDTH'(fm_ff.octant) << OCTANT_SHIFT;
      if (!fm_ff.yzero) begin
         angle_in = angle_in + rnd[ANGLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[OUT_STAGE]) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp_angle = angle_ff;

endmodule
